// File: rtl/llcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package llcm_pkg;

  // Width of one slice of the narrow operand in the pipelined multipliers.
  localparam int MUL_CHUNK = 16;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEGEN = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

endpackage
`default_nettype wire

// File: rtl/llcm_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module llcm_mul
  import llcm_pkg::*;
#(
  parameter int AW = 32,
  parameter int BW = 33
) (
  input  wire                         clk_i,
  input  wire                         en_i,
  input  wire signed [AW-1:0]         a_i,
  input  wire signed [BW-1:0]         b_i,
  output logic signed [AW+BW-1:0]     p_o
);

  // One slice of b per stage; the top slice carries the sign.
  localparam int NC = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int EW = NC * MUL_CHUNK;
  localparam int XW = AW + EW + 1;

  logic signed [AW-1:0] a_q   [NC-1];
  logic signed [EW-1:0] b_q   [NC-1];
  logic signed [XW-1:0] acc_q [NC];
  logic signed [EW-1:0] b_ext;

  assign b_ext = EW'(b_i);

  for (genvar k = 0; k < NC; k++) begin : g_st
    logic signed [AW-1:0]          a_s;
    logic signed [EW-1:0]          b_s;
    logic signed [XW-1:0]          acc_s;
    logic signed [AW+MUL_CHUNK:0]  pp;

    if (k == 0) begin : g_first
      assign a_s   = a_i;
      assign b_s   = b_ext;
      assign acc_s = '0;
    end else begin : g_next
      assign a_s   = a_q[k-1];
      assign b_s   = b_q[k-1];
      assign acc_s = acc_q[k-1];
    end

    if (k == NC - 1) begin : g_top
      assign pp = a_s * $signed(b_s[k*MUL_CHUNK +: MUL_CHUNK]);
    end else begin : g_low
      assign pp = a_s * $signed({1'b0, b_s[k*MUL_CHUNK +: MUL_CHUNK]});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[k] <= acc_s + (XW'(pp) <<< (k * MUL_CHUNK));
      end
    end

    if (k < NC - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          a_q[k] <= a_s;
          b_q[k] <= b_s;
        end
      end
    end
  end

  assign p_o = acc_q[NC-1][AW+BW-1:0];

endmodule
`default_nettype wire

// File: rtl/line_line_closest_midpoint.sv
`timescale 1ns / 1ps
`default_nettype none
// Midpoint of the shortest segment between two 3D lines, each given as a base point and a
// direction in signed fixed point. Every value is computed exactly with wide integers and the
// midpoint is rounded once toward minus infinity, so the result in raw LSBs does not depend on
// where the binary point sits. The block takes one transfer per clock while its skid register
// is empty. When the output stalls, one more result is caught by the skid register behind the
// output register; after that the whole pipeline holds and the input is not ready until the
// output moves again. The pipeline is built from sliced multipliers (16 bits of the narrow
// operand per stage, three multiplier levels in a row) and a restoring divider, which retires
// one quotient bit per stage. Parallel lines or a zero direction give a zero midpoint with
// status degenerate; a coordinate outside the range saturates and sets status saturated.
module line_line_closest_midpoint
  import llcm_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  wire                                        s_axis_tvalid,
  output logic                                       s_axis_tready,
  // From bit 0 up: a_point_x, a_point_y, a_point_z, a_dir_x, a_dir_y, a_dir_z,
  // b_point_x, b_point_y, b_point_z, b_dir_x, b_dir_y, b_dir_z, zero padding.
  input  wire [((12*COORD_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  wire                                        m_axis_tready,
  // From bit 0 up: mid_x, mid_y, mid_z, status, zero padding.
  output logic [((3*COORD_WIDTH+2+7)/8)*8-1:0]       m_axis_tdata
);

  localparam int W    = COORD_WIDTH;
  localparam int OW   = ((3 * W + 2 + 7) / 8) * 8;
  localparam int CW   = W + 1;            // differences, sums and quotient bits
  localparam int DW   = 2 * CW + 2;       // dot products
  localparam int PW   = 2 * DW;           // product of two dot products
  localparam int NW   = PW + 1;           // den and numa
  localparam int DDW  = NW + DW;          // dd
  localparam int NBW  = DDW + 1;          // numb
  localparam int DVW  = DDW + 1;          // divisor 2*dd
  localparam int NUMW = DDW + CW + 3;     // numerator per coordinate
  localparam int HW   = NUMW - CW;        // part of the numerator above the quotient bits
  localparam int LD   = (DW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int LC   = (CW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int S4   = 3 + LD + 1;
  localparam int S5   = S4 + LD + 1;
  localparam int S6   = S5 + LC + 1;
  localparam int SF   = S6 + CW + 2;

  // Dot product slots.
  localparam int D1343 = 0;  // w . ub
  localparam int D4321 = 1;  // ub . ua
  localparam int D1321 = 2;  // w . ua
  localparam int D4343 = 3;  // ub . ub
  localparam int D2121 = 4;  // ua . ua

  // The whole pipeline advances together; it only halts while the skid register is full.
  logic en;
  logic sk_v_q;
  logic o_v_q;
  logic [SF-1:0] v_q;

  assign en            = !sk_v_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[SF-2:0], s_axis_tvalid};
    end
  end

  // Input fields.
  logic signed [W-1:0] pa [3];
  logic signed [W-1:0] ua [3];
  logic signed [W-1:0] pb [3];
  logic signed [W-1:0] ub [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa[k] = s_axis_tdata[k*W +: W];
      ua[k] = s_axis_tdata[(3+k)*W +: W];
      pb[k] = s_axis_tdata[(6+k)*W +: W];
      ub[k] = s_axis_tdata[(9+k)*W +: W];
    end
  end

  // Stage 1: w = pa - pb, s = pa + pb; directions enter their delay lines.
  logic signed [CW-1:0] w_q     [3];
  logic signed [CW-1:0] ua_dl_q [S4][3];
  logic signed [CW-1:0] ub_dl_q [S5][3];
  logic signed [CW-1:0] s_dl_q  [S5][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        w_q[k]        <= CW'(pa[k]) - CW'(pb[k]);
        s_dl_q[0][k]  <= CW'(pa[k]) + CW'(pb[k]);
        ua_dl_q[0][k] <= CW'(ua[k]);
        ub_dl_q[0][k] <= CW'(ub[k]);
      end
      for (int i = 1; i < S4; i++) begin
        ua_dl_q[i] <= ua_dl_q[i-1];
      end
      for (int i = 1; i < S5; i++) begin
        ub_dl_q[i] <= ub_dl_q[i-1];
        s_dl_q[i]  <= s_dl_q[i-1];
      end
    end
  end

  // Stage 2: the fifteen coordinate products.
  logic signed [2*CW-1:0] pr_q [5][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pr_q[D1343][k] <= w_q[k] * ub_dl_q[0][k];
        pr_q[D4321][k] <= ub_dl_q[0][k] * ua_dl_q[0][k];
        pr_q[D1321][k] <= w_q[k] * ua_dl_q[0][k];
        pr_q[D4343][k] <= ub_dl_q[0][k] * ub_dl_q[0][k];
        pr_q[D2121][k] <= ua_dl_q[0][k] * ua_dl_q[0][k];
      end
    end
  end

  // Stage 3: dot products, held in a delay line for the later multiplier levels.
  logic signed [DW-1:0] dt_q [LD+LC+3][5];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int d = 0; d < 5; d++) begin
        dt_q[0][d] <= DW'(pr_q[d][0]) + DW'(pr_q[d][1]) + DW'(pr_q[d][2]);
      end
      for (int i = 1; i < LD + LC + 3; i++) begin
        dt_q[i] <= dt_q[i-1];
      end
    end
  end

  // First multiplier level: products of dot products.
  logic signed [PW-1:0] ma_aabb, ma_abab, ma_1343, ma_1321;

  llcm_mul #(.AW(DW), .BW(DW)) u_mul_aabb (
    .clk_i(clk_i), .en_i(en), .a_i(dt_q[0][D2121]), .b_i(dt_q[0][D4343]), .p_o(ma_aabb)
  );
  llcm_mul #(.AW(DW), .BW(DW)) u_mul_abab (
    .clk_i(clk_i), .en_i(en), .a_i(dt_q[0][D4321]), .b_i(dt_q[0][D4321]), .p_o(ma_abab)
  );
  llcm_mul #(.AW(DW), .BW(DW)) u_mul_1343 (
    .clk_i(clk_i), .en_i(en), .a_i(dt_q[0][D1343]), .b_i(dt_q[0][D4321]), .p_o(ma_1343)
  );
  llcm_mul #(.AW(DW), .BW(DW)) u_mul_1321 (
    .clk_i(clk_i), .en_i(en), .a_i(dt_q[0][D1321]), .b_i(dt_q[0][D4343]), .p_o(ma_1321)
  );

  // Stage S4: denominator, numerator of ta and the degenerate flag.
  logic signed [NW-1:0] den_c;
  logic signed [NW-1:0] den_q, numa_q;
  logic                 deg_c;
  logic                 dg_q [S6-S4+1];

  assign den_c = NW'(ma_aabb) - NW'(ma_abab);
  assign deg_c = den_c[NW-1] || (den_c == '0) || (dt_q[LD][D4343] == '0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q    <= den_c;
      numa_q   <= NW'(ma_1343) - NW'(ma_1321);
      dg_q[0]  <= deg_c;
      for (int i = 1; i < S6 - S4 + 1; i++) begin
        dg_q[i] <= dg_q[i-1];
      end
    end
  end

  // Second multiplier level.
  logic signed [DDW-1:0]   mb_den1343, mb_numa4321, mb_dd;
  logic signed [NW+CW-1:0] mb_numaua [3];

  llcm_mul #(.AW(NW), .BW(DW)) u_mul_den1343 (
    .clk_i(clk_i), .en_i(en), .a_i(den_q), .b_i(dt_q[LD+1][D1343]), .p_o(mb_den1343)
  );
  llcm_mul #(.AW(NW), .BW(DW)) u_mul_numa4321 (
    .clk_i(clk_i), .en_i(en), .a_i(numa_q), .b_i(dt_q[LD+1][D4321]), .p_o(mb_numa4321)
  );
  llcm_mul #(.AW(NW), .BW(DW)) u_mul_dd (
    .clk_i(clk_i), .en_i(en), .a_i(den_q), .b_i(dt_q[LD+1][D4343]), .p_o(mb_dd)
  );

  // Stage S5: numerator of tb and the common denominator dd.
  logic signed [NBW-1:0]   numb_q;
  logic signed [DDW-1:0]   dd_dl_q [LC+1];
  logic signed [NW+CW-1:0] um_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      numb_q     <= NBW'(mb_den1343) + NBW'(mb_numa4321);
      dd_dl_q[0] <= mb_dd;
      for (int i = 1; i < LC + 1; i++) begin
        dd_dl_q[i] <= dd_dl_q[i-1];
      end
      um_q <= mb_numaua;
    end
  end

  // Third level: each coordinate's three numerator terms; the lanes also hold numa * ua.
  logic signed [DDW+CW-1:0] mc_t2 [3];
  logic signed [DDW+CW-1:0] mc_t1 [3];
  logic signed [NBW+CW-1:0] mc_t3 [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    llcm_mul #(.AW(NW), .BW(CW)) u_mul_numaua (
      .clk_i(clk_i), .en_i(en), .a_i(numa_q), .b_i(ua_dl_q[S4-1][k]), .p_o(mb_numaua[k])
    );
    llcm_mul #(.AW(NW+CW), .BW(DW)) u_mul_t2 (
      .clk_i(clk_i), .en_i(en), .a_i(um_q[k]), .b_i(dt_q[LD+LC+2][D4343]), .p_o(mc_t2[k])
    );
    llcm_mul #(.AW(DDW), .BW(CW)) u_mul_t1 (
      .clk_i(clk_i), .en_i(en), .a_i(dd_dl_q[0]), .b_i(s_dl_q[S5-1][k]), .p_o(mc_t1[k])
    );
    llcm_mul #(.AW(NBW), .BW(CW)) u_mul_t3 (
      .clk_i(clk_i), .en_i(en), .a_i(numb_q), .b_i(ub_dl_q[S5-1][k]), .p_o(mc_t3[k])
    );
  end

  // Stage S6: numerators and the divisor 2*dd.
  logic signed [NUMW-1:0] n_q [3];
  logic [DVW-1:0]         dv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        n_q[k] <= NUMW'(mc_t1[k]) + NUMW'(mc_t2[k]) + NUMW'(mc_t3[k]);
      end
      dv_q <= {dd_dl_q[LC][DDW-1:0], 1'b0};
    end
  end

  // Divider: one setup stage, then one restoring step per quotient bit.
  logic [DVW-1:0] ds_dv_q  [CW+1];
  logic           ds_dg_q  [CW+1];
  logic [DVW-1:0] rem_q    [CW+1][3];
  logic [CW-1:0]  ml_q     [CW+1][3];
  logic [CW-1:0]  qt_q     [CW+1][3];
  logic           ng_q     [CW+1][3];
  logic           bg_q     [CW+1][3];

  logic [NUMW-1:0] mag_c [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_c[k] = n_q[k][NUMW-1] ? (~n_q[k] + NUMW'(1)) : n_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ds_dv_q[0] <= dv_q;
      ds_dg_q[0] <= dg_q[S6-S4];
      for (int k = 0; k < 3; k++) begin
        rem_q[0][k] <= mag_c[k][CW +: DVW];
        ml_q[0][k]  <= mag_c[k][CW-1:0];
        qt_q[0][k]  <= '0;
        ng_q[0][k]  <= n_q[k][NUMW-1];
        bg_q[0][k]  <= mag_c[k][NUMW-1:CW] >= HW'(dv_q);
      end
    end
  end

  for (genvar j = 1; j <= CW; j++) begin : g_div
    logic [DVW:0] r2   [3];
    logic         ge   [3];

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        r2[k] = {rem_q[j-1][k], ml_q[j-1][k][CW-1]};
        ge[k] = r2[k] >= {1'b0, ds_dv_q[j-1]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ds_dv_q[j] <= ds_dv_q[j-1];
        ds_dg_q[j] <= ds_dg_q[j-1];
        for (int k = 0; k < 3; k++) begin
          rem_q[j][k] <= ge[k] ? DVW'(r2[k] - {1'b0, ds_dv_q[j-1]}) : r2[k][DVW-1:0];
          ml_q[j][k]  <= {ml_q[j-1][k][CW-2:0], 1'b0};
          qt_q[j][k]  <= {qt_q[j-1][k][CW-2:0], ge[k]};
          ng_q[j][k]  <= ng_q[j-1][k];
          bg_q[j][k]  <= bg_q[j-1][k];
        end
      end
    end
  end

  // Final stage: floor rounding for negative values, saturation and status.
  localparam logic [CW:0] LimNeg = (CW+1)'(1) << (W - 1);

  logic [W-1:0] fm_c [3];
  logic         sat_c [3];
  logic [CW:0]  mag1;
  logic [W-1:0] fm_q [3];
  status_e      fst_c, fst_q;

  always_comb begin
    mag1 = '0;
    for (int k = 0; k < 3; k++) begin
      mag1 = {1'b0, qt_q[CW][k]} + (CW+1)'(rem_q[CW][k] != '0);
      if (!ng_q[CW][k]) begin
        sat_c[k] = bg_q[CW][k] || ({1'b0, qt_q[CW][k]} > (LimNeg - (CW+1)'(1)));
        fm_c[k]  = sat_c[k] ? {1'b0, {(W-1){1'b1}}} : qt_q[CW][k][W-1:0];
      end else begin
        sat_c[k] = bg_q[CW][k] || (mag1 > LimNeg);
        fm_c[k]  = sat_c[k] ? {1'b1, {(W-1){1'b0}}} : W'(~mag1 + (CW+1)'(1));
      end
      if (ds_dg_q[CW]) begin
        fm_c[k] = '0;
      end
    end
    if (ds_dg_q[CW]) begin
      fst_c = ST_DEGEN;
    end else if (sat_c[0] || sat_c[1] || sat_c[2]) begin
      fst_c = ST_SAT;
    end else begin
      fst_c = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fm_q  <= fm_c;
      fst_q <= fst_c;
    end
  end

  // Output register with a skid register behind it.
  logic [3*W+1:0] fin_word;
  logic [3*W+1:0] o_q, sk_q;

  assign fin_word = {fst_q, fm_q[2], fm_q[1], fm_q[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q  <= 1'b0;
      sk_v_q <= 1'b0;
    end else if (sk_v_q) begin
      if (m_axis_tready) begin
        sk_v_q <= 1'b0;
      end
    end else if (!o_v_q || m_axis_tready) begin
      o_v_q <= v_q[SF-1];
    end else if (v_q[SF-1]) begin
      sk_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_v_q) begin
      if (m_axis_tready) begin
        o_q <= sk_q;
      end
    end else if (!o_v_q || m_axis_tready) begin
      o_q <= fin_word;
    end else begin
      sk_q <= fin_word;
    end
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = OW'(o_q);

endmodule
`default_nettype wire

// File: rtl/llcm_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module llcm_chk
  import llcm_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input wire                                  clk_i,
  input wire                                  rst_ni,
  input wire                                  m_axis_tvalid,
  input wire                                  m_axis_tready,
  input wire [((3*COORD_WIDTH+2+7)/8)*8-1:0]  m_axis_tdata
);

  localparam int W = COORD_WIDTH;

  logic [W-1:0] mx, my, mz;
  logic [1:0]   st;

  assign mx = m_axis_tdata[W-1:0];
  assign my = m_axis_tdata[2*W-1:W];
  assign mz = m_axis_tdata[3*W-1:2*W];
  assign st = m_axis_tdata[3*W+1:3*W];

  // A degenerate pair always reports the origin.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && st == ST_DEGEN) |-> (mx == '0 && my == '0 && mz == '0))
    else $error("degenerate result with a non-zero midpoint");

  // A saturated result has at least one coordinate pinned to a bound.
  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && st == ST_SAT) |->
      (mx == {1'b0, {(W-1){1'b1}}} || mx == {1'b1, {(W-1){1'b0}}} ||
       my == {1'b0, {(W-1){1'b1}}} || my == {1'b1, {(W-1){1'b0}}} ||
       mz == {1'b0, {(W-1){1'b1}}} || mz == {1'b1, {(W-1){1'b0}}}))
    else $error("saturated status without a coordinate at a bound");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result withdrawn before its transfer");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind line_line_closest_midpoint llcm_chk #(.COORD_WIDTH(COORD_WIDTH)) u_llcm_chk (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// File: verif/llcm_checker.sv
`timescale 1ns / 1ps
// Watches both channels, predicts the midpoint of every accepted line pair exactly with wide
// integers and compares each output transfer with the oldest prediction.
module llcm_checker
  import llcm_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  input  wire          s_axis_tready,
  input  wire  [383:0] s_axis_tdata,
  input  wire          m_axis_tvalid,
  input  wire          m_axis_tready,
  input  wire  [103:0] m_axis_tdata,
  output int           fail_count_o,
  output int           pending_o
);

  typedef logic signed [319:0] wint_t;

  typedef struct {
    logic [31:0] mid [3];
    status_e     status;
  } midpoint_t;

  midpoint_t expected_mids [$];
  int        errors = 0;

  assign fail_count_o = errors;
  assign pending_o    = expected_mids.size();

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Floor of n / d for d > 0, clipped to the signed 32-bit range.
  function automatic logic [31:0] floor_div_clip(input wint_t n, input wint_t d,
                                                 inout logic clipped);
    wint_t q;
    q = n / d;
    if ((n % d != 0) && n < 0) q = q - 1;
    if (q > 32'sh7fffffff) begin
      clipped = 1'b1;
      return 32'h7fffffff;
    end
    if (q < -wint_t'(64'sh80000000)) begin
      clipped = 1'b1;
      return 32'h80000000;
    end
    return q[31:0];
  endfunction

  function automatic midpoint_t closest_midpoint(input logic [383:0] d);
    wint_t pa [3], ua [3], pb [3], ub [3], w [3];
    wint_t w_ub, ub_ua, w_ua, ub_ub, ua_ua, den, numa, numb, dd, dv, n;
    logic clipped;
    midpoint_t r;
    clipped = 1'b0;
    for (int k = 0; k < 3; k++) begin
      pa[k] = $signed(d[k*32 +: 32]);
      ua[k] = $signed(d[(3+k)*32 +: 32]);
      pb[k] = $signed(d[(6+k)*32 +: 32]);
      ub[k] = $signed(d[(9+k)*32 +: 32]);
      w[k]  = pa[k] - pb[k];
    end
    w_ub  = w[0]*ub[0]  + w[1]*ub[1]  + w[2]*ub[2];
    ub_ua = ub[0]*ua[0] + ub[1]*ua[1] + ub[2]*ua[2];
    w_ua  = w[0]*ua[0]  + w[1]*ua[1]  + w[2]*ua[2];
    ub_ub = ub[0]*ub[0] + ub[1]*ub[1] + ub[2]*ub[2];
    ua_ua = ua[0]*ua[0] + ua[1]*ua[1] + ua[2]*ua[2];
    den   = ua_ua*ub_ub - ub_ua*ub_ua;
    if (den <= 0 || ub_ub == 0) begin
      r.mid = '{32'd0, 32'd0, 32'd0};
      r.status = ST_DEGEN;
      return r;
    end
    numa = w_ub*ub_ua - w_ua*ub_ub;
    numb = w_ub*den + numa*ub_ua;
    dd   = ub_ub*den;
    dv   = 2*dd;
    for (int k = 0; k < 3; k++) begin
      n = (pa[k] + pb[k])*dd + numa*ua[k]*ub_ub + numb*ub[k];
      r.mid[k] = floor_div_clip(n, dv, clipped);
    end
    r.status = clipped ? ST_SAT : ST_OK;
    return r;
  endfunction

  always @(posedge clk_i) begin
    midpoint_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_mids.insert(expected_mids.size(), closest_midpoint(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_mids.size() == 0) begin
          report_mismatch("output transfer with no prediction waiting");
        end else begin
          want = expected_mids.pop_front();
          for (int k = 0; k < 3; k++)
            if (m_axis_tdata[k*32 +: 32] !== want.mid[k])
              report_mismatch($sformatf("mid[%0d] got %h want %h", k,
                                        m_axis_tdata[k*32 +: 32], want.mid[k]));
          if (m_axis_tdata[97:96] !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", m_axis_tdata[97:96],
                                      want.status));
        end
      end
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the closest-midpoint block. Line pairs are offered on the input
// stream; the checker beside the block predicts and compares every result.
module testbench;
  import llcm_pkg::*;

  localparam int LATENCY = 55;
  localparam int STALL_LIMIT = 4000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [383:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  int           fail_count, pending;
  int           tx_idle_pct = 12;
  int           rx_idle_pct = 57;
  logic         rx_hold = 1'b0;
  int           quiet_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  line_line_closest_midpoint DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  llcm_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // The receiver stalls at random unless a long hold-off is in force.
  always @(posedge clk_i)
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offers one line pair and holds it until it is taken; may then leave a gap.
  task automatic offer_pair(input logic signed [31:0] f [12]);
    logic [383:0] d;
    for (int k = 0; k < 12; k++) d[k*32 +: 32] = f[k];
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  function automatic logic signed [31:0] rnd_span(input int bits);
    return $signed($urandom_range((1 << bits) - 1)) - (1 << (bits - 1));
  endfunction

  // Most pairs are ordinary skew lines whose midpoint fits; some use the full range and
  // mostly saturate; the rest are parallel lines or have a zero direction.
  task automatic offer_random_pair();
    logic signed [31:0] f [12];
    int kind, scale, base;
    kind = $urandom_range(99);
    for (int k = 0; k < 3; k++) begin
      f[k]   = rnd_span(25);
      f[6+k] = rnd_span(25);
      f[3+k] = rnd_span(19);
      f[9+k] = rnd_span(19);
    end
    if (kind >= 70 && kind < 85) begin
      for (int k = 0; k < 12; k++) f[k] = $urandom;
    end else if (kind >= 85 && kind < 95) begin
      scale = $urandom_range(1, 6) * ($urandom_range(1) ? 1 : -1);
      for (int k = 0; k < 3; k++) f[9+k] = f[3+k] * scale;
    end else if (kind >= 95) begin
      base = $urandom_range(1) ? 3 : 9;
      for (int k = 0; k < 3; k++) f[base + k] = 0;
    end
    offer_pair(f);
  endtask

  localparam logic signed [31:0] ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pairs: all zero, a zero direction on either line, parallel and anti-parallel
    // lines, perpendicular lines with an exact midpoint, extreme coordinates at both ends of the
    // range, and the extremes of every field.
    offer_pair('{default: 0});
    offer_pair('{0, 0, 0, 0, 0, 0, ONE, ONE, ONE, ONE, 0, 0});
    offer_pair('{ONE, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0, 0});
    offer_pair('{0, 0, 0, ONE, ONE, 0, ONE, 0, 0, 2*ONE, 2*ONE, 0});
    offer_pair('{0, 0, 0, ONE, 0, 0, 0, 0, ONE, -ONE, 0, 0});
    offer_pair('{0, 0, 0, ONE, 0, 0, 0, 0, 2*ONE, 0, ONE, 0});
    offer_pair('{3, -5, 7, 1, 0, 0, -2, 9, -11, 0, 1, 0});
    offer_pair('{ONE, -ONE, 0, 0, 0, ONE, -ONE, ONE, 0, ONE, ONE, 0});
    offer_pair('{MAXV, MAXV, MAXV, 1, 0, 0, MAXV, MAXV, MAXV, 0, 1, 0});
    offer_pair('{MINV, MINV, MINV, 1, 0, 0, MINV, MINV, MINV, 0, 1, 0});
    offer_pair('{MAXV, MINV, MAXV, MINV, MAXV, MINV, MINV, MAXV, MINV, MAXV, MINV, 1});
    offer_pair('{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV});
    offer_pair('{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
    offer_pair('{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 0, 1});
    offer_pair('{0, 0, 0, MINV, 0, 0, 0, 0, 0, 0, MINV, 0});
    offer_pair('{0, 0, 0, 1, 1, 1, 5, 0, 0, 1, -1, 0});
    offer_pair('{-7, 0, 0, 0, 3, 0, 0, 0, 0, 0, 0, 3});

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 57 : 0;
      rx_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 12 : 0;
      if (phase == 2) begin
        // Long receiver hold-off while pairs keep coming, so the pipeline backs up.
        fork
          begin
            rx_hold <= 1'b1;
            repeat (400) @(posedge clk_i);
            rx_hold <= 1'b0;
          end
        join_none
      end
      repeat (530) offer_random_pair();
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: line_line_closest_midpoint.f
rtl/llcm_pkg.sv
rtl/llcm_mul.sv
rtl/line_line_closest_midpoint.sv
rtl/llcm_chk.sv
verif/llcm_checker.sv
verif/testbench.sv
